// ===== src/stpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper half-step sequencer package
// Shared types, codes, widths and the half-step beat table.
// ----------------------------------------------------------------------------
package stpr_pkg;

   localparam int unsigned SPEED_W    = 20;
   localparam int unsigned RATE_W     = 21;
   localparam int unsigned POS_W      = 32;
   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned DIV_W      = 32;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam int unsigned DEF_TICK_HZ     = 1000000;
   localparam int unsigned DEF_MIN_STEP_HZ = 1;
   localparam int unsigned DEF_MAX_STEP_HZ = 1000;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_SPEED = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_SPEED,
      KIND_STOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic              rev;
      logic [RATE_W-1:0] rate;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_APPLY
   } back_state_type;

   function automatic logic [3:0] beat_pattern(input logic [2:0] idx);
      logic [3:0] pat;
      case (idx)
         3'd0: pat = 4'h1;
         3'd1: pat = 4'h3;
         3'd2: pat = 4'h2;
         3'd3: pat = 4'h6;
         3'd4: pat = 4'h4;
         3'd5: pat = 4'hC;
         3'd6: pat = 4'h8;
         3'd7: pat = 4'h9;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

endpackage

// ===== src/stepper_half_step_sequencer.sv =====
// ----------------------------------------------------------------------------
// Stepper half-step sequencer
// Drives a four-coil unipolar stepper in eight-beat half-step order.
//
// Each req item is either a timer tick (tuser 0) or a signed speed command
// (tuser 1) in 1/16 steps per second. Every item yields exactly one rsp item
// with the coil drive, position and running, stepped and held flags.
// Limits are written on the csr channel, which is always ready; write them
// only while no item is in flight.
// Tick and stop items are answered straight from the idle state. A speed item
// first runs the bit-serial period divider, which retires one quotient bit
// per cycle over 32 bits, and then applies the new period.
// Items are worked off one at a time by the step engine; a two-entry queue
// keeps req accepting while it is busy and while a result waits on rsp.
// When rsp stalls, the result register holds and the queue fills, after which
// req_tready drops. Reset empties the queue, stops the motor with all coils
// off, clears the position and restores both limits to the full range.
// ----------------------------------------------------------------------------
module stepper_half_step_sequencer #(
   parameter int unsigned TICK_HZ     = stpr_pkg::DEF_TICK_HZ,
   parameter int unsigned MIN_STEP_HZ = stpr_pkg::DEF_MIN_STEP_HZ,
   parameter int unsigned MAX_STEP_HZ = stpr_pkg::DEF_MAX_STEP_HZ
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [stpr_pkg::REQ_DATA_W-1:0]      req_tdata,  // speed[19:0], zero pad
   input  logic                                 req_tuser,  // op
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // coils[3:0], position[35:4], running[36], stepped[37], held_at_limit[38], pad
   output logic [stpr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [stpr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stpr_pkg::POS_W-1:0]           csr_data
);
   import stpr_pkg::*;

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   stpr_front #(
      .MIN_STEP_HZ (MIN_STEP_HZ),
      .MAX_STEP_HZ (MAX_STEP_HZ)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   stpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_cmd    (push_cmd),
      .out_valid (cmd_valid),
      .out_pop   (cmd_pop),
      .out_cmd   (cmd)
   );

   stpr_back #(
      .TICK_HZ     (TICK_HZ),
      .MIN_STEP_HZ (MIN_STEP_HZ),
      .MAX_STEP_HZ (MAX_STEP_HZ)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== src/stpr_front.sv =====
// ----------------------------------------------------------------------------
// Stepper sequencer front end
// Accepts request items and classifies them as tick, speed or stop commands,
// taking the speed magnitude and clamping it to the allowed step rate range.
// ----------------------------------------------------------------------------
module stpr_front #(
   parameter int unsigned MIN_STEP_HZ = stpr_pkg::DEF_MIN_STEP_HZ,
   parameter int unsigned MAX_STEP_HZ = stpr_pkg::DEF_MAX_STEP_HZ
) (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [stpr_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tuser,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output stpr_pkg::cmd_type                    push_cmd
);
   import stpr_pkg::*;

   localparam logic [RATE_W-1:0] RATE_LO = RATE_W'(16 * MIN_STEP_HZ);
   localparam logic [RATE_W-1:0] RATE_HI = RATE_W'(16 * MAX_STEP_HZ);

   logic signed [SPEED_W-1:0] speed;
   logic                      neg;
   logic [SPEED_W-1:0]        mag;
   logic [RATE_W-1:0]         mag_ext;
   logic [RATE_W-1:0]         rate_lo_clamped;

   assign speed           = req_tdata[SPEED_W-1:0];
   assign neg             = speed[SPEED_W-1];
   assign mag             = neg ? (~speed + 1'b1) : speed;
   assign mag_ext         = {1'b0, mag};
   assign rate_lo_clamped = (mag_ext < RATE_LO) ? RATE_LO : mag_ext;

   always_comb begin
      push_cmd.rev  = neg;
      push_cmd.rate = (rate_lo_clamped > RATE_HI) ? RATE_HI : rate_lo_clamped;
      if (req_tuser == OP_TICK) begin
         push_cmd.kind = KIND_TICK;
      end else if (mag_ext < RATE_LO) begin
         push_cmd.kind = KIND_STOP;
      end else begin
         push_cmd.kind = KIND_SPEED;
      end
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

// ===== src/stpr_queue.sv =====
// ----------------------------------------------------------------------------
// Stepper sequencer command queue
// Two-entry queue that decouples the front end from the step engine.
// ----------------------------------------------------------------------------
module stpr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  stpr_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_pop,
   output stpr_pkg::cmd_type out_cmd
);
   import stpr_pkg::*;

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== src/stpr_back.sv =====
// ----------------------------------------------------------------------------
// Stepper sequencer step engine
// Executes queued commands: tick counting, limit checks and beat stepping,
// and a bit-serial divider that turns a step rate into a timer period.
// ----------------------------------------------------------------------------
module stpr_back #(
   parameter int unsigned TICK_HZ     = stpr_pkg::DEF_TICK_HZ,
   parameter int unsigned MIN_STEP_HZ = stpr_pkg::DEF_MIN_STEP_HZ,
   parameter int unsigned MAX_STEP_HZ = stpr_pkg::DEF_MAX_STEP_HZ
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   output logic                                 cmd_pop,
   input  stpr_pkg::cmd_type                    cmd,
   input  logic                                 csr_valid,
   input  logic [stpr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stpr_pkg::POS_W-1:0]           csr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [stpr_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import stpr_pkg::*;

   localparam longint unsigned RESET_RATE = (MIN_STEP_HZ > MAX_STEP_HZ) ?
                                            16 * MAX_STEP_HZ : 16 * MIN_STEP_HZ;
   localparam longint unsigned RESET_Q    = (64'(TICK_HZ) * 16) / RESET_RATE;
   localparam longint unsigned RESET_P    = (RESET_Q <= 1) ? 1 :
                                            (RESET_Q > 65536) ? 65535 : RESET_Q - 1;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(RESET_P);
   localparam logic [DIV_W-1:0]    DIVIDEND     = DIV_W'(64'(TICK_HZ) * 64'd16);
   localparam int unsigned         ITER_W       = $clog2(DIV_W);
   localparam logic [ITER_W-1:0]   ITER_LAST    = ITER_W'(DIV_W - 1);
   localparam logic [DIV_W-1:0]    Q_MAX        = DIV_W'(65536);

   back_state_type           state_ff;
   back_state_type           state_in;
   logic signed [POS_W-1:0]  lower_ff;
   logic signed [POS_W-1:0]  upper_ff;
   logic [2:0]               phase_ff;
   logic [2:0]               phase_in;
   logic                     reverse_ff;
   logic                     reverse_in;
   logic signed [POS_W-1:0]  count_ff;
   logic signed [POS_W-1:0]  count_in;
   logic [PERIOD_W-1:0]      period_ff;
   logic [PERIOD_W-1:0]      period_in;
   logic [PERIOD_W-1:0]      tick_ff;
   logic [PERIOD_W-1:0]      tick_in;
   logic                     enabled_ff;
   logic                     enabled_in;
   logic [3:0]               coil_ff;
   logic [3:0]               coil_in;
   logic                     cmd_rev_ff;
   logic                     cmd_rev_in;
   logic [RATE_W-1:0]        divisor_ff;
   logic [RATE_W-1:0]        divisor_in;
   logic [RATE_W-1:0]        rem_ff;
   logic [RATE_W-1:0]        rem_in;
   logic [DIV_W-1:0]         quo_ff;
   logic [DIV_W-1:0]         quo_in;
   logic [ITER_W-1:0]        iter_ff;
   logic [ITER_W-1:0]        iter_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_in;

   logic                     out_free;
   logic                     out_load;
   logic                     stepped;
   logic                     held;
   logic [RATE_W:0]          rem_shift;
   logic [RATE_W+1:0]        rem_diff;
   logic [PERIOD_W-1:0]      new_period;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cmd_pop    = (state_ff == ST_IDLE) && cmd_valid && out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rem_shift  = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_diff   = {1'b0, rem_shift} - {2'b00, divisor_ff};
   assign new_period = (quo_ff <= DIV_W'(1)) ? PERIOD_W'(1) :
                       (quo_ff > Q_MAX) ? {PERIOD_W{1'b1}} :
                       PERIOD_W'(quo_ff - DIV_W'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && cmd.kind == KIND_SPEED) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (iter_ff == ITER_LAST) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      reverse_in = reverse_ff;
      count_in   = count_ff;
      period_in  = period_ff;
      tick_in    = tick_ff;
      enabled_in = enabled_ff;
      coil_in    = coil_ff;
      cmd_rev_in = cmd_rev_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      iter_in    = iter_ff;
      out_load   = 1'b0;
      stepped    = 1'b0;
      held       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               case (cmd.kind)
                  KIND_SPEED: begin
                     cmd_rev_in = cmd.rev;
                     divisor_in = cmd.rate;
                     rem_in     = '0;
                     quo_in     = DIVIDEND;
                     iter_in    = '0;
                  end
                  KIND_STOP: begin
                     coil_in    = 4'h0;
                     enabled_in = 1'b0;
                     out_load   = 1'b1;
                  end
                  KIND_TICK: begin
                     out_load = 1'b1;
                     if (enabled_ff) begin
                        if (tick_ff >= period_ff) begin
                           tick_in = '0;
                           if (!reverse_ff) begin
                              if (count_ff >= upper_ff) begin
                                 held = 1'b1;
                              end else begin
                                 coil_in  = beat_pattern(phase_ff);
                                 phase_in = phase_ff + 3'd1;
                                 count_in = count_ff + 32'sd1;
                                 stepped  = 1'b1;
                              end
                           end else begin
                              if (count_ff <= lower_ff) begin
                                 held = 1'b1;
                              end else begin
                                 coil_in  = beat_pattern(phase_ff);
                                 phase_in = phase_ff - 3'd1;
                                 count_in = count_ff - 32'sd1;
                                 stepped  = 1'b1;
                              end
                           end
                        end else begin
                           tick_in = tick_ff + PERIOD_W'(1);
                        end
                     end
                  end
                  default: out_load = 1'b1;
               endcase
            end
         end
         ST_DIVIDE: begin
            iter_in = iter_ff + ITER_W'(1);
            if (!rem_diff[RATE_W+1]) begin
               rem_in = rem_diff[RATE_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[RATE_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               out_load   = 1'b1;
               reverse_in = cmd_rev_ff;
               period_in  = new_period;
               enabled_in = 1'b1;
               if (!enabled_ff || tick_ff > new_period) begin
                  tick_in = '0;
               end
            end
         end
         default: begin
         end
      endcase

      rsp_data_in  = {1'b0, held, stepped, enabled_in, count_in, coil_in};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lower_ff     <= 32'sh8000_0000;
         upper_ff     <= 32'sh7FFF_FFFF;
         phase_ff     <= 3'd0;
         reverse_ff   <= 1'b0;
         count_ff     <= '0;
         period_ff    <= RESET_PERIOD;
         tick_ff      <= '0;
         enabled_ff   <= 1'b0;
         coil_ff      <= 4'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         reverse_ff   <= reverse_in;
         count_ff     <= count_in;
         period_ff    <= period_in;
         tick_ff      <= tick_in;
         enabled_ff   <= enabled_in;
         coil_ff      <= coil_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_LOWER_LIMIT: lower_ff <= csr_data;
               CSR_UPPER_LIMIT: upper_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_rev_ff <= cmd_rev_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      iter_ff    <= iter_in;
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== test/stepper_motion_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper half-step sequencer monitor
// Watches the req, rsp and csr channels of the sequencer and keeps its own
// model of the motor: beat index, direction, position, step period, tick
// counter, run state and the two position limits. Every accepted req item
// adds one expected status, and every accepted rsp item is compared field by
// field against the oldest one.
// ----------------------------------------------------------------------------
module stepper_motion_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [stpr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [stpr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [stpr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stpr_pkg::POS_W-1:0]        csr_data,
   output int                                mismatch_count,
   output int                                items_outstanding
);
   import stpr_pkg::*;

   localparam int unsigned RATE_LO = 16 * DEF_MIN_STEP_HZ;
   localparam int unsigned RATE_HI = 16 * DEF_MAX_STEP_HZ;
   localparam logic [31:0] BEAT_TABLE =
      {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

   // Same bit order as rsp_tdata[38:0].
   typedef struct packed {
      logic        held;
      logic        stepped;
      logic        running;
      logic [31:0] position;
      logic [3:0]  coils;
   } motor_status_type;

   motor_status_type status_due[$];

   logic [2:0]         beat_idx;
   logic               going_reverse;
   logic signed [31:0] step_pos;
   logic [15:0]        step_period;
   logic [15:0]        tick_cnt;
   logic               running;
   logic [3:0]         coil_drive;
   logic signed [31:0] lower_lim;
   logic signed [31:0] upper_lim;
   int                 results_seen;

   function automatic logic [15:0] period_for_rate(input logic [20:0] rate);
      logic [63:0] r;
      logic [63:0] q;
      r = 64'(rate);
      if (r < 64'(RATE_LO)) r = 64'(RATE_LO);
      if (r > 64'(RATE_HI)) r = 64'(RATE_HI);
      q = 64'(DEF_TICK_HZ);
      q = (q * 64'd16) / r;
      if (q != 64'd0) q = q - 64'd1;
      if (q == 64'd0) q = 64'd1;
      if (q > 64'hFFFF) q = 64'hFFFF;
      return q[15:0];
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at rsp item %0d: %s", results_seen, msg);
   endtask

   task automatic advance_motor(input logic op, input logic [SPEED_W-1:0] spd);
      motor_status_type st;
      logic [20:0]      mag;
      logic             stepped;
      logic             held;
      stepped = 1'b0;
      held = 1'b0;
      if (op == OP_SPEED) begin
         mag = spd[SPEED_W-1] ? (21'h100000 - {1'b0, spd}) : {1'b0, spd};
         if (mag < RATE_LO) begin
            coil_drive = 4'h0;
            running = 1'b0;
         end else begin
            going_reverse = spd[SPEED_W-1];
            step_period = period_for_rate(mag);
            if (tick_cnt > step_period) tick_cnt = '0;
            if (!running) begin
               tick_cnt = '0;
               running = 1'b1;
            end
         end
      end else if (running) begin
         if (tick_cnt >= step_period) begin
            tick_cnt = '0;
            if (going_reverse ? (step_pos <= lower_lim) : (step_pos >= upper_lim)) begin
               held = 1'b1;
            end else begin
               coil_drive = BEAT_TABLE[{beat_idx, 2'b00} +: 4];
               beat_idx = going_reverse ? beat_idx - 3'd1 : beat_idx + 3'd1;
               step_pos = going_reverse ? step_pos - 1 : step_pos + 1;
               stepped = 1'b1;
            end
         end else begin
            tick_cnt = tick_cnt + 16'd1;
         end
      end
      st.coils = coil_drive;
      st.position = step_pos;
      st.running = running;
      st.stepped = stepped;
      st.held = held;
      status_due.push_back(st);
   endtask

   always @(posedge clock) begin : watch
      motor_status_type got;
      motor_status_type want;
      if (reset) begin
         beat_idx = '0;
         going_reverse = 1'b0;
         step_pos = '0;
         step_period = period_for_rate(21'(RATE_LO));
         tick_cnt = '0;
         running = 1'b0;
         coil_drive = 4'h0;
         lower_lim = 32'h8000_0000;
         upper_lim = 32'h7FFF_FFFF;
         results_seen = 0;
         mismatch_count = 0;
         status_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LOWER_LIMIT) lower_lim = csr_data;
            else if (csr_index == CSR_UPPER_LIMIT) upper_lim = csr_data;
         end
         // A result can never answer an item taken at the same edge, so
         // results are checked before the new item is predicted.
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = rsp_tdata[38:0];
            if (status_due.size() == 0) begin
               flag_mismatch("result with no item outstanding");
            end else begin
               want = status_due.pop_front();
               if (got.coils !== want.coils)
                  flag_mismatch($sformatf("coils %h, expected %h", got.coils, want.coils));
               if (got.position !== want.position)
                  flag_mismatch($sformatf("position %0d, expected %0d",
                     $signed(got.position), $signed(want.position)));
               if (got.running !== want.running)
                  flag_mismatch($sformatf("running %b, expected %b", got.running, want.running));
               if (got.stepped !== want.stepped)
                  flag_mismatch($sformatf("stepped %b, expected %b", got.stepped, want.stepped));
               if (got.held !== want.held)
                  flag_mismatch($sformatf("held_at_limit %b, expected %b", got.held, want.held));
            end
         end
         if (req_tvalid && req_tready) advance_motor(req_tuser, req_tdata[SPEED_W-1:0]);
      end
      items_outstanding = status_due.size();
   end

endmodule

// ===== test/tb_stepper_half_step_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper half-step sequencer testbench
// Drives speed and tick items into the sequencer, first a directed set of
// edge speeds, then short runs of ticks behind random speed commands in both
// directions. Limits are rewritten between runs while the block is idle.
// Both stream sides idle at varying rates; the monitor predicts and checks
// every result.
// ----------------------------------------------------------------------------
module tb_stepper_half_step_sequencer;
   import stpr_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tuser = OP_TICK;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_LOWER_LIMIT;
   logic [POS_W-1:0]        csr_data = '0;
   int                      mismatch_count;
   int                      items_outstanding;
   int unsigned             send_idle_pct = 7;
   int unsigned             recv_idle_pct = 64;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   stepper_half_step_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   stepper_motion_monitor u_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .items_outstanding (items_outstanding)
   );

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic send_item(input logic op, input logic [SPEED_W-1:0] spd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tuser <= op;
      req_tdata <= {{(REQ_DATA_W-SPEED_W){1'b0}}, spd};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic quiesce(input int settle_cycles);
      req_tvalid <= 1'b0;
      while (items_outstanding != 0) @(negedge clock);
      repeat (settle_cycles) @(negedge clock);
   endtask

   task automatic set_limits(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
      quiesce(4);
      for (int r = 0; r < 2; r++) begin
         csr_index <= (r == 0) ? CSR_LOWER_LIMIT : CSR_UPPER_LIMIT;
         csr_data <= (r == 0) ? lo : hi;
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [POS_W-1:0] pick_limit();
      int unsigned roll;
      int          v;
      roll = $urandom_range(99);
      if (roll < 70) begin
         v = $urandom_range(12);
         return v - 6;
      end
      if (roll < 80) return 32'h8000_0000;
      if (roll < 90) return 32'h7FFF_FFFF;
      return $urandom;
   endfunction

   function automatic logic [SPEED_W-1:0] pick_speed();
      int unsigned       roll;
      logic [SPEED_W-1:0] v;
      roll = $urandom_range(99);
      if (roll < 55) v = SPEED_W'($urandom_range(524287, 16000));
      else if (roll < 70) v = SPEED_W'($urandom_range(15999, 1000));
      else if (roll < 80) return SPEED_W'($urandom);
      else if (roll < 92) v = SPEED_W'($urandom_range(15));
      else v = SPEED_W'($urandom_range(999, 16));
      if ($urandom_range(1) == 1) v = -v;
      return v;
   endfunction

   initial begin
      int burst;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_limits(32'h8000_0000, 32'h7FFF_FFFF);

      send_item(OP_TICK, 20'hFFFFF);
      send_item(OP_SPEED, 20'd0);
      send_item(OP_SPEED, 20'd15);
      send_item(OP_SPEED, -20'sd15);
      send_item(OP_TICK, 20'h55555);
      send_item(OP_SPEED, 20'd16);
      send_item(OP_TICK, 20'hAAAAA);
      send_item(OP_TICK, 20'h00000);
      send_item(OP_SPEED, -20'sd16);
      send_item(OP_SPEED, 20'd16000);
      send_item(OP_SPEED, 20'd16001);
      send_item(OP_SPEED, 20'h7FFFF);
      send_item(OP_SPEED, 20'h80000);
      send_item(OP_SPEED, 20'd1000);
      send_item(OP_TICK, 20'h12345);
      send_item(OP_SPEED, -20'sd17);
      send_item(OP_SPEED, 20'd17);
      send_item(OP_SPEED, 20'd1);
      send_item(OP_TICK, 20'hEDCBA);
      send_item(OP_SPEED, -20'sd1);
      send_item(OP_SPEED, 20'h0FFFF);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 64 : 0;
         recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 7 : 0;
         case (phase)
            0: set_limits(-2, 2);
            1: set_limits(3, -3);
            default: set_limits(32'h7FFF_FFFF, 32'h8000_0000);
         endcase
         for (int seg = 0; seg < 16; seg++) begin
            if (seg != 0 && $urandom_range(99) < 30) set_limits(pick_limit(), pick_limit());
            send_item(OP_SPEED, pick_speed());
            burst = $urandom_range(40, 1);
            repeat (burst) begin
               if ($urandom_range(99) == 0) send_item(OP_SPEED, pick_speed());
               else send_item(OP_TICK, SPEED_W'($urandom));
            end
         end
      end

      quiesce(40);
      if (mismatch_count == 0 && items_outstanding == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #80_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/stpr_pkg.sv
src/stpr_front.sv
src/stpr_queue.sv
src/stpr_back.sv
src/stepper_half_step_sequencer.sv
test/stepper_motion_monitor.sv
test/tb_stepper_half_step_sequencer.sv
